### sv/hsvs_pkg.sv
// Shared types, codes and constants of the HSV color range segmenter.
package hsvs_pkg;

    // Operation codes
    localparam logic [1:0] OP_CLEAR    = 2'd0;
    localparam logic [1:0] OP_LEARN    = 2'd1;
    localparam logic [1:0] OP_CLASSIFY = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    // Hue sector codes (which channel holds the maximum)
    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam logic [16:0] HUE_SECTOR = 17'd15360;
    localparam logic [16:0] HUE_FULL   = 17'd92160;
    localparam logic [31:0] MARKER_RESET = 32'hFFE600CB;
    localparam int DIV_STEPS = 24;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] pixel;
    } hsvs_in_t;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        matched;
    } hsvs_out_t;

    // Pre-classified job handed from front to back
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] pixel;
        logic [7:0]  max_val;
        logic [7:0]  delta;
        logic [1:0]  sector;
        logic        negative;
        logic [7:0]  abs_num;
    } hsvs_job_t;

endpackage

### sv/hsvs_front.sv
// Front end: accepts items, finds max/min, sector and hue numerator.
module hsvs_front (
    input  hsvs_pkg::hsvs_in_t  item,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                queue_full,
    output logic                push,
    output hsvs_pkg::hsvs_job_t job
);
    import hsvs_pkg::*;

    logic [7:0] red, green, blue, mx, mn, pos, neg;
    logic [1:0] sector;

    // Find extremes and the sector of the maximum
    always_comb
    begin
        red   = item.pixel[7:0];
        green = item.pixel[15:8];
        blue  = item.pixel[23:16];
        mx = (red > green) ? red : green;
        mx = (mx > blue) ? mx : blue;
        mn = (red < green) ? red : green;
        mn = (mn < blue) ? mn : blue;
        if (red == mx)
        begin
            sector = SEC_RED;   pos = green; neg = blue;
        end
        else if (green == mx)
        begin
            sector = SEC_GREEN; pos = blue;  neg = red;
        end
        else
        begin
            sector = SEC_BLUE;  pos = red;   neg = green;
        end
    end

    // Build the job; drop the unused operation code at accept
    always_comb
    begin
        job.operation = item.operation;
        job.pixel     = item.pixel;
        job.max_val   = mx;
        job.delta     = mx - mn;
        job.sector    = sector;
        job.negative  = (pos < neg);
        job.abs_num   = (pos < neg) ? (neg - pos) : (pos - neg);
    end

    assign item_ready = !queue_full;
    assign push = item_valid && item_ready && (item.operation != OP_NONE);

endmodule

### sv/hsvs_queue.sv
// Short job queue between front and back.
module hsvs_queue #(
    parameter int DEPTH = hsvs_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hsvs_pkg::hsvs_job_t wdata,
    input  logic                pop,
    output hsvs_pkg::hsvs_job_t rdata,
    output logic                full,
    output logic                empty
);
    import hsvs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hsvs_job_t         mem [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign rdata = mem[rd_ptr_reg];
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

### sv/hsvs_back.sv
// Back end: serial divider for S and H, bound update and result register.
module hsvs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_data,
    input  logic                queue_empty,
    input  hsvs_pkg::hsvs_job_t job,
    output logic                pop,
    output hsvs_pkg::hsvs_out_t result,
    output logic                result_valid,
    input  logic                result_ready
);
    import hsvs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV_S = 2'd1;
    localparam logic [1:0] ST_DIV_H = 2'd2;
    localparam logic [1:0] ST_APPLY = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [4:0]  cnt_reg;
    logic [23:0] dvd_reg;
    logic [7:0]  rem_reg, divisor_reg;
    logic [16:0] sq_reg;
    hsvs_job_t   job_reg;
    logic [31:0] marker_reg;
    logic        have_sample_reg, hue_known_reg;
    logic [16:0] hue_low_reg, hue_high_reg;
    logic [15:0] sat_low_reg, sat_high_reg;
    logic [7:0]  val_low_reg, val_high_reg;
    hsvs_out_t   result_reg;
    logic        result_valid_reg;

    logic [8:0]  shifted;
    logic        qbit;
    logic [7:0]  rem_new;
    logic [23:0] dvd_new;
    logic        last_step;
    logic [16:0] base, hue, qc;
    logic [15:0] sat;
    logic        hue_ok, hit, out_free, finish;

    // One restoring division step
    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[23]};
        qbit      = (shifted >= {1'b0, divisor_reg});
        rem_new   = qbit ? 8'(shifted - {1'b0, divisor_reg}) : shifted[7:0];
        dvd_new   = {dvd_reg[22:0], qbit};
        last_step = (cnt_reg == 5'(DIV_STEPS - 1));
    end

    // Form hue, saturation and the match
    always_comb
    begin
        case (job_reg.sector)
            SEC_RED:   base = 17'd0;
            SEC_GREEN: base = HUE_SECTOR << 1;
            SEC_BLUE:  base = HUE_SECTOR << 2;
            default:   base = 17'd0;
        endcase
        qc = dvd_reg[16:0] + 17'(job_reg.negative && (rem_reg != 8'd0));
        if (!job_reg.negative)
        begin
            hue = base + qc;
        end
        else if (base >= qc)
        begin
            hue = base - qc;
        end
        else
        begin
            hue = base + HUE_FULL - qc;
        end
        if (job_reg.max_val == 8'd0)
        begin
            sat = 16'd0;
        end
        else
        begin
            sat = sq_reg[16] ? 16'hFFFF : sq_reg[15:0];
        end
        hue_ok = (job_reg.delta != 8'd0);
        hit = have_sample_reg && hue_known_reg && hue_ok
            && hue >= hue_low_reg && hue <= hue_high_reg
            && sat >= sat_low_reg && sat <= sat_high_reg
            && job_reg.max_val >= val_low_reg && job_reg.max_val <= val_high_reg;
        out_free = !result_valid_reg || result_ready;
    end

    // Sequence the work on one job
    always_comb
    begin
        state_next = state_reg;
        pop    = 1'b0;
        finish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop = 1'b1;
                    if (job.operation != OP_CLEAR)
                    begin
                        state_next = ST_DIV_S;
                    end
                end
            end
            ST_DIV_S:
            begin
                if (last_step)
                begin
                    state_next = ST_DIV_H;
                end
            end
            ST_DIV_H:
            begin
                if (last_step)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (job_reg.operation != OP_CLASSIFY || out_free)
                begin
                    finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && pop)
        begin
            job_reg     <= job;
            dvd_reg     <= {job.delta, 16'd0};
            divisor_reg <= job.max_val;
            rem_reg     <= 8'd0;
            cnt_reg     <= 5'd0;
        end
        else if (state_reg == ST_DIV_S || state_reg == ST_DIV_H)
        begin
            if (last_step && state_reg == ST_DIV_S)
            begin
                sq_reg      <= dvd_new[16:0];
                dvd_reg     <= 24'(job_reg.abs_num) * 24'(HUE_SECTOR);
                divisor_reg <= job_reg.delta;
                rem_reg     <= 8'd0;
                cnt_reg     <= 5'd0;
            end
            else
            begin
                dvd_reg <= dvd_new;
                rem_reg <= rem_new;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        if (finish && job_reg.operation == OP_CLASSIFY)
        begin
            result_reg.pixel_out <= hit ? marker_reg : job_reg.pixel;
            result_reg.matched   <= hit;
        end
    end

    // Control, bounds and marker register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            marker_reg       <= MARKER_RESET;
            have_sample_reg  <= 1'b0;
            hue_known_reg    <= 1'b0;
            hue_low_reg      <= '0;
            hue_high_reg     <= '0;
            sat_low_reg      <= '0;
            sat_high_reg     <= '0;
            val_low_reg      <= '0;
            val_high_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                marker_reg <= cfg_data;
            end
            if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (finish && job_reg.operation == OP_CLASSIFY)
            begin
                result_valid_reg <= 1'b1;
            end
            // Clear bounds
            if (state_reg == ST_IDLE && pop && job.operation == OP_CLEAR)
            begin
                have_sample_reg <= 1'b0;
                hue_known_reg   <= 1'b0;
                hue_low_reg     <= '0;
                hue_high_reg    <= '0;
                sat_low_reg     <= '0;
                sat_high_reg    <= '0;
                val_low_reg     <= '0;
                val_high_reg    <= '0;
            end
            // Widen bounds with a learned sample
            if (finish && job_reg.operation == OP_LEARN)
            begin
                have_sample_reg <= 1'b1;
                if (!have_sample_reg || sat < sat_low_reg)
                    sat_low_reg <= sat;
                if (!have_sample_reg || sat > sat_high_reg)
                    sat_high_reg <= sat;
                if (!have_sample_reg || job_reg.max_val < val_low_reg)
                    val_low_reg <= job_reg.max_val;
                if (!have_sample_reg || job_reg.max_val > val_high_reg)
                    val_high_reg <= job_reg.max_val;
                if (hue_ok)
                begin
                    hue_known_reg <= 1'b1;
                    if (!hue_known_reg || hue < hue_low_reg)
                        hue_low_reg <= hue;
                    if (!hue_known_reg || hue > hue_high_reg)
                        hue_high_reg <= hue;
                end
            end
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

### sv/hsv_color_range_segmenter.sv
// Top level of the HSV color range segmenter.
//
// Items arrive on item/item_valid/item_ready: an operation (clear, learn,
// classify) and a packed RGBA pixel. Classify items give one transaction on
// result/result_valid/result_ready: the marker color when the pixel lies in
// the learned hue, saturation and value bounds, else the pixel unchanged.
// Clear and learn give no result; operation code 3 is dropped on accept.
// The marker color is written through cfg_we/cfg_data at any idle time.
//
// A learn or classify item passes through the back end in order: pop, the
// bit-serial divider for saturation, then the divider for hue, then the
// apply step, which registers a classify result. A clear is done at pop.
// The shared divider means the back end works on one pixel at a time. A two-entry
// queue lets the front accept while the back is busy.
// Reset empties the queue and the bounds and loads the default marker.
// When the receiver stalls, the result holds and the back end waits in
// its apply step; the queue then fills and item_ready drops.
module hsv_color_range_segmenter #(
    parameter int QUEUE_DEPTH = hsvs_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hsvs_pkg::hsvs_in_t  item,
    input  logic                item_valid,
    output logic                item_ready,
    output hsvs_pkg::hsvs_out_t result,
    output logic                result_valid,
    input  logic                result_ready,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_data
);
    import hsvs_pkg::*;

    logic      push, pop, full, empty;
    hsvs_job_t job_in, job_out;

    hsvs_front u_front (
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .queue_full (full),
        .push       (push),
        .job        (job_in)
    );

    hsvs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (job_in),
        .pop   (pop),
        .rdata (job_out),
        .full  (full),
        .empty (empty)
    );

    hsvs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .queue_empty  (empty),
        .job          (job_out),
        .pop          (pop),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

### sv/hsvs_checker.sv
// Port-level checks of the segmenter and their binding to the top level.
module hsvs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input hsvs_pkg::hsvs_out_t result,
    input logic                result_valid,
    input logic                result_ready
);
    // Result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // No result during reset
    a_reset: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result valid in reset");

    // Ready drops only after an accepted transaction fills the queue
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(item_ready) |-> $past(item_valid && item_ready))
        else $error("ready fell without a transaction");

    // A new result never appears right after reset release
    a_first: assert property (@(posedge clk)
        !rst_n ##1 rst_n |-> !result_valid)
        else $error("result right after reset");

endmodule

bind hsv_color_range_segmenter hsvs_checker u_hsvs_checker (.*);

### dv/hsv_color_range_checker.sv
// Checker for the HSV color range segmenter: predicts classify results and compares them.
module hsv_color_range_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  hsvs_pkg::hsvs_in_t  item,
    input  logic                item_valid,
    input  logic                item_ready,
    input  hsvs_pkg::hsvs_out_t result,
    input  logic                result_valid,
    input  logic                result_ready,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_data,
    output int                  error_count,
    output int                  pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import hsvs_pkg::*;

    logic [31:0] marker;
    logic        have_sample;
    logic        hue_known;
    logic [16:0] hue_lo;
    logic [16:0] hue_hi;
    logic [15:0] sat_lo;
    logic [15:0] sat_hi;
    logic [7:0]  val_lo;
    logic [7:0]  val_hi;
    hsvs_out_t   expected_results[$];

    // Convert a pixel to fixed-point HSV; return 0 when hue is undefined
    function automatic bit pixel_to_hsv(input logic [31:0] px, output int h, output int s,
                                        output int v);
        int r;
        int g;
        int b;
        int mx;
        int mn;
        int d;
        int num;
        int hue;
        r = px[7:0];
        g = px[15:8];
        b = px[23:16];
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        d = mx - mn;
        v = mx;
        h = 0;
        s = 0;
        if (mx == 0)
            return 0;
        s = (65536 * d) / mx;
        if (s > 65535)
            s = 65535;
        if (d == 0)
            return 0;
        if (r == mx)
        begin
            hue = 0;
            num = g - b;
        end
        else if (g == mx)
        begin
            hue = 2 * 15360;
            num = b - r;
        end
        else
        begin
            hue = 4 * 15360;
            num = r - g;
        end
        // Floor toward minus infinity
        if (num >= 0)
            hue += (15360 * num) / d;
        else
            hue -= (15360 * (-num) + d - 1) / d;
        if (hue < 0)
            hue += 92160;
        h = hue;
        return 1;
    endfunction

    // Track state and compare on each handshake
    always @(posedge clk or negedge rst_n)
    begin
        int  h;
        int  s;
        int  v;
        bit  hue_ok;
        bit  hit;
        hsvs_out_t want;
        if (!rst_n)
        begin
            marker <= MARKER_RESET;
            have_sample <= 0;
            hue_known <= 0;
            hue_lo <= '0;
            hue_hi <= '0;
            sat_lo <= '0;
            sat_hi <= '0;
            val_lo <= '0;
            val_hi <= '0;
            expected_results.delete();
            error_count <= 0;
        end
        else
        begin
            if (cfg_we)
                marker <= cfg_data;
            if (item_valid && item_ready)
            begin
                hue_ok = pixel_to_hsv(item.pixel, h, s, v);
                case (item.operation)
                    OP_CLEAR:
                    begin
                        have_sample <= 0;
                        hue_known <= 0;
                        hue_lo <= '0;
                        hue_hi <= '0;
                        sat_lo <= '0;
                        sat_hi <= '0;
                        val_lo <= '0;
                        val_hi <= '0;
                    end
                    OP_LEARN:
                    begin
                        have_sample <= 1;
                        if (!have_sample || s < sat_lo)
                            sat_lo <= 16'(s);
                        if (!have_sample || s > sat_hi)
                            sat_hi <= 16'(s);
                        if (!have_sample || v < val_lo)
                            val_lo <= 8'(v);
                        if (!have_sample || v > val_hi)
                            val_hi <= 8'(v);
                        if (hue_ok)
                        begin
                            hue_known <= 1;
                            if (!hue_known || h < hue_lo)
                                hue_lo <= 17'(h);
                            if (!hue_known || h > hue_hi)
                                hue_hi <= 17'(h);
                        end
                    end
                    OP_CLASSIFY:
                    begin
                        hit = have_sample && hue_known && hue_ok && h >= hue_lo
                              && h <= hue_hi && s >= sat_lo && s <= sat_hi
                              && v >= val_lo && v <= val_hi;
                        want.pixel_out = hit ? marker : item.pixel;
                        want.matched = hit;
                        expected_results.push_back(want);
                    end
                    default: ;
                endcase
            end
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (error_count < 10)
                        $display("unexpected result %h/%0b", result.pixel_out,
                                 result.matched);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.pixel_out !== want.pixel_out || result.matched !== want.matched)
                    begin
                        if (error_count < 10)
                            $display("mismatch: expected %h/%0b got %h/%0b",
                                     want.pixel_out, want.matched,
                                     result.pixel_out, result.matched);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

    assign pending_count = expected_results.size();

endmodule

### dv/hsv_color_range_segmenter_test.sv
// Top of the HSV color range segmenter testbench: stimulus, reset and verdict.
module hsv_color_range_segmenter_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hsvs_pkg::*;

    logic        clk;
    logic        rst_n;
    hsvs_in_t    item;
    logic        item_valid;
    logic        item_ready;
    hsvs_out_t   result;
    logic        result_valid;
    logic        result_ready;
    logic        cfg_we;
    logic [31:0] cfg_data;
    int          error_count;
    int          pending_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;

    hsv_color_range_segmenter dut (
        .clk(clk), .rst_n(rst_n), .item(item), .item_valid(item_valid),
        .item_ready(item_ready), .result(result), .result_valid(result_valid),
        .result_ready(result_ready), .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    hsv_color_range_checker checker_i (
        .clk(clk), .rst_n(rst_n), .item(item), .item_valid(item_valid),
        .item_ready(item_ready), .result(result), .result_valid(result_valid),
        .result_ready(result_ready), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .error_count(error_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Drive receiver stalls, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            result_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one transaction, holding it until accepted; called at a falling edge
    task automatic send_item(input logic [1:0] op, input logic [31:0] px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item.operation <= op;
        item.pixel <= px;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Wait for all results, then drain the back end before a register write
    task automatic drain_and_write(input logic [31:0] value);
        item_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random pixel near a base color so learned ranges get hits
    function automatic logic [31:0] near_pixel(input logic [31:0] base);
        logic [31:0] px;
        int k;
        int c;
        px = $urandom;
        for (k = 0; k < 3; k++)
        begin
            c = base[8*k +: 8] + $urandom_range(16) - 8;
            c = (c < 0) ? 0 : ((c > 255) ? 255 : c);
            px[8*k +: 8] = 8'(c);
        end
        return px;
    endfunction

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [31:0] base;
        logic [31:0] markers[4];
        int ph;
        int n;
        int j;
        markers = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 32'h1234_5678};
        rst_n = 1'b0;
        item = '0;
        item_valid = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        result_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: classify before learning, achromatic, extremes, wraparound hue
        send_item(OP_CLASSIFY, 32'h0000_00FF);
        send_item(OP_LEARN, 32'h0000_0000);
        send_item(OP_CLASSIFY, 32'h0000_0000);
        send_item(OP_LEARN, 32'h7F80_8080);
        send_item(OP_CLASSIFY, 32'h0080_8080);
        send_item(OP_LEARN, 32'hAA10_00FF);
        send_item(OP_LEARN, 32'h00FF_00FF);
        send_item(OP_CLASSIFY, 32'h1200_00FF);
        send_item(OP_CLASSIFY, 32'hFFFF_FFFF);
        send_item(OP_CLASSIFY, 32'h0080_0080);
        send_item(OP_NONE, 32'h0000_00FF);
        send_item(OP_CLASSIFY, 32'h0000_00FF);
        send_item(OP_LEARN, 32'h0000_FF00);
        send_item(OP_LEARN, 32'h00FF_0000);
        send_item(OP_CLASSIFY, 32'h0001_FF00);
        send_item(OP_CLASSIFY, 32'hFF01_0203);
        send_item(OP_CLEAR, 32'hFFFF_FFFF);
        send_item(OP_CLASSIFY, 32'h0000_00FF);
        send_item(OP_LEARN, 32'h0001_0000);
        send_item(OP_CLASSIFY, 32'h0001_0000);

        // Long hold-off so the queue fills and input stalls
        hold_off_cycles = 400;
        for (j = 0; j < 8; j++)
            send_item(OP_CLASSIFY, $urandom);

        // Random phases with varied idling and marker settings
        for (ph = 0; ph < 8; ph++)
        begin
            drain_and_write(markers[ph % 4]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (n = 0; n < 165; n++)
            begin
                if (n % 60 == 0)
                begin
                    base = $urandom;
                    send_item(OP_CLEAR, $urandom);
                    for (j = 0; j < 4; j++)
                        send_item(OP_LEARN, near_pixel(base));
                end
                j = $urandom_range(99);
                if (j < 70)
                    send_item(OP_CLASSIFY, near_pixel(base));
                else if (j < 85)
                    send_item(OP_CLASSIFY, $urandom);
                else if (j < 93)
                    send_item(OP_LEARN, near_pixel(base));
                else
                    send_item(2'($urandom_range(3)), $urandom);
            end
        end

        item_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
